FILE: rtl/slpc_pkg.sv
// shared types for the serial line pin change detector
`default_nettype none
package slpc_pkg;

	localparam int unsigned VALUE_W = 32;

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
	} sample_t;

endpackage
`default_nettype wire

FILE: rtl/serial_line_pin_change_detector_unit.sv
// top level of the serial line pin change detector
//
//   port group   handshake              payload
//   rx input     in_valid / in_ready    rx_byte
//   events       out_valid / out_ready  output_index, level, last_event
//   config       psel/penable/pwrite    paddr, pwdata, prdata (64 bit)
//
// the parser takes one byte per cycle while the sample queue has room
// each number line costs the emitter a pop plus one event per changed output,
// set by the single emitter loop over changed outputs
// reset clears all control state at once, no clearing pass
// a full event register stalls the emitter; a full queue stalls the parser
`default_nettype none
module serial_line_pin_change_detector_unit #(
	parameter int unsigned NUM_OUTPUTS = 8,
	parameter int unsigned LINE_BYTES  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       output_index,
	output logic             level,
	output logic             last_event,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import slpc_pkg::*;

	localparam logic REG_ACTIVE  = 1'b0;
	localparam logic REG_PIN_MAP = 1'b1;

	logic [3:0]  active_q;
	logic [39:0] pin_map_q;
	logic        wr_en, accept, q_full, pop;
	sample_t     push, head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			pin_map_q <= '0;
		end else if (wr_en) begin
			if (paddr[3] == REG_ACTIVE) begin
				active_q <= pwdata[3:0];
			end
			if (paddr[3] == REG_PIN_MAP) begin
				pin_map_q <= pwdata[39:0];
			end
		end
	end

	assign prdata = (paddr[3] == REG_PIN_MAP) ? {24'b0, pin_map_q} : {60'b0, active_q};

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	slpc_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.rx_byte(rx_byte),
		.push   (push)
	);

	slpc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.full  (q_full)
	);

	slpc_back #(
		.NUM_OUTPUTS(NUM_OUTPUTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.active_outputs(active_q),
		.pin_map       (pin_map_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.output_index  (output_index),
		.level         (level),
		.last_event    (last_event)
	);

endmodule
`default_nettype wire

FILE: rtl/slpc_front.sv
// line assembler and decimal parser that pushes one sample per number line
`default_nettype none
module slpc_front #(
	parameter int unsigned LINE_BYTES = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       rx_byte,
	output slpc_pkg::sample_t     push
);
	import slpc_pkg::*;

	localparam int unsigned LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	typedef enum logic [4:0] {
		PH_FIRST  = 5'b00001,
		PH_SPACE  = 5'b00010,
		PH_DIGITS = 5'b00100,
		PH_DONE   = 5'b01000,
		PH_OTHER  = 5'b10000
	} phase_t;

	logic [LEN_W-1:0]   len_q, len_d, len_e;
	phase_t             phase_q, phase_d, phase_e;
	logic               neg_q, neg_d, neg_e;
	logic [VALUE_W-1:0] acc_q, acc_d, acc_e, acc_ten;
	logic               clr, is_ws, is_sign, is_digit;

	always_comb begin
		clr     = (len_q == LEN_MAX);
		len_e   = clr ? '0 : len_q;
		phase_e = clr ? PH_FIRST : phase_q;
		neg_e   = clr ? 1'b0 : neg_q;
		acc_e   = clr ? '0 : acc_q;

		is_ws    = (rx_byte == CH_SPACE) || (rx_byte inside {[8'd9:8'd13]});
		is_sign  = (rx_byte == CH_MINUS) || (rx_byte == CH_PLUS);
		is_digit = rx_byte inside {[8'h30:8'h39]};
		acc_ten  = (acc_e << 3) + (acc_e << 1) + VALUE_W'(rx_byte[3:0]);

		len_d   = len_e;
		phase_d = phase_e;
		neg_d   = neg_e;
		acc_d   = acc_e;
		push.valid = 1'b0;
		push.value = neg_e ? (~acc_e + 1'b1) : acc_e;

		if (rx_byte == CH_LF) begin
			push.valid = accept && (phase_e inside {PH_SPACE, PH_DIGITS, PH_DONE});
			len_d   = '0;
			phase_d = PH_FIRST;
			neg_d   = 1'b0;
			acc_d   = '0;
		end else begin
			len_d = len_e + 1'b1;
			case (phase_e)
				PH_FIRST: begin
					phase_d = (rx_byte == CH_V) ? PH_SPACE : PH_OTHER;
				end
				PH_SPACE: begin
					if (is_ws) begin
						phase_d = PH_SPACE;
					end else if (is_sign) begin
						neg_d   = (rx_byte == CH_MINUS);
						phase_d = PH_DIGITS;
					end else if (is_digit) begin
						acc_d   = acc_ten;
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						acc_d = acc_ten;
					end else begin
						phase_d = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			phase_q <= PH_FIRST;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (accept) begin
			len_q   <= len_d;
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/slpc_queue.sv
// two-entry sample queue between the parser and the event emitter
`default_nettype none
module slpc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slpc_pkg::sample_t push,
	input  wire logic             pop,
	output slpc_pkg::sample_t     head,
	output logic                  full
);
	import slpc_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	logic [VALUE_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [PTR_W:0]     cnt_q;
	logic               do_pop;

	assign full       = (cnt_q == (PTR_W + 1)'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.value = slot_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_q] <= push.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push.valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/slpc_back.sv
// pin level sampler and per-output change event emitter
`default_nettype none
module slpc_back #(
	parameter int unsigned NUM_OUTPUTS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slpc_pkg::sample_t head,
	output logic                  pop,
	input  wire logic [3:0]       active_outputs,
	input  wire logic [39:0]      pin_map,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            output_index,
	output logic                  level,
	output logic                  last_event
);
	import slpc_pkg::*;

	logic [NUM_OUTPUTS-1:0] prev_q, lv_q, pend_q;
	logic [NUM_OUTPUTS-1:0] lv_new, act, sel_oh;
	logic                   first_q, out_valid_q, take, emit;
	logic [3:0]             cnt;
	logic [2:0]             sel_idx, output_index_q;
	logic                   level_q, last_q;

	always_comb begin
		cnt = (active_outputs > 4'(NUM_OUTPUTS)) ? 4'(NUM_OUTPUTS) : active_outputs;
		for (int i = 0; i < NUM_OUTPUTS; i++) begin
			lv_new[i] = head.value[pin_map[5*i +: 5]];
			act[i]    = (4'(i) < cnt);
		end
		sel_oh  = pend_q & (~pend_q + 1'b1);
		sel_idx = '0;
		for (int i = 0; i < NUM_OUTPUTS; i++) begin
			if (sel_oh[i]) begin
				sel_idx = sel_idx | 3'(i);
			end
		end
	end

	assign pop  = head.valid && (pend_q == '0);
	assign take = !out_valid_q || out_ready;
	assign emit = take && (pend_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			lv_q        <= '0;
			pend_q      <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pend_q  <= first_q ? '0 : ((lv_new ^ prev_q) & act);
				lv_q    <= lv_new;
				prev_q  <= lv_new;
				first_q <= 1'b0;
			end else if (emit) begin
				pend_q <= pend_q & ~sel_oh;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			output_index_q <= sel_idx;
			level_q        <= |(lv_q & sel_oh);
			last_q         <= ((pend_q & ~sel_oh) == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign output_index = output_index_q;
	assign level        = level_q;
	assign last_event   = last_q;

endmodule
`default_nettype wire
